/* hdl/lid_pkg.sv */
// shared types and constants for the logical immediate decode unit
// no dependencies; imported by lid_decode and logical_immediate_decode_unit
package lid_pkg;

    localparam int CODE_W  = 13;
    localparam int FIELD_W = 6;
    localparam int MASK_W  = 64;

    // width of the input tdata bus: the code padded to whole bytes
    localparam int S_TDATA_W = ((CODE_W + 7) / 8) * 8;

    // code field positions
    localparam int N_BIT   = 12;
    localparam int ROT_LSB = 6;
    localparam int SZ_LSB  = 0;

    localparam logic [FIELD_W-1:0] FIELD_ONES = 6'h3f;

    typedef struct packed {
        logic              code_valid;
        logic [MASK_W-1:0] mask_value;
    } lid_result_t;

endpackage

/* hdl/lid_decode.sv */
// combinational expansion of a 13-bit logical immediate code into a 64-bit mask
// depends on lid_pkg
module lid_decode (
    input  logic [lid_pkg::CODE_W-1:0] imm_code,
    output lid_pkg::lid_result_t       result
);
    import lid_pkg::*;

    logic               n_bit;
    logic [FIELD_W-1:0] rot;
    logic [FIELD_W-1:0] sz;
    logic [FIELD_W-1:0] lvl;       // esize - 1
    logic               no_zero;
    logic [FIELD_W-1:0] s_val;
    logic [FIELD_W-1:0] r_val;
    logic               bad;
    logic [MASK_W-1:0]  rep;       // replicated, unrotated pattern
    logic [2*MASK_W-1:0] dbl;

    assign n_bit = imm_code[N_BIT];
    assign rot   = imm_code[ROT_LSB +: FIELD_W];
    assign sz    = imm_code[SZ_LSB +: FIELD_W];

    // element size from n and the highest zero of sz[5:1]
    always_comb begin
        no_zero = 1'b0;
        if (n_bit) begin
            lvl = FIELD_ONES;
        end else if (!sz[5]) begin
            lvl = 6'h1f;
        end else if (!sz[4]) begin
            lvl = 6'h0f;
        end else if (!sz[3]) begin
            lvl = 6'h07;
        end else if (!sz[2]) begin
            lvl = 6'h03;
        end else if (!sz[1]) begin
            lvl = 6'h01;
        end else begin
            lvl     = '0;
            no_zero = 1'b1;
        end
    end

    assign s_val = sz & lvl;
    assign r_val = rot & lvl;

    // rotate bits above the element are only illegal for n = 0
    assign bad = no_zero || (s_val == lvl) || (!n_bit && ((rot & ~lvl) != '0));

    // bit i of the replicated element is set when its in-element position <= s
    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            rep[i] = ((FIELD_W'(i) & lvl) <= s_val);
        end
    end

    // the pattern repeats every element, so a full-width rotate equals
    // rotating each element on its own
    assign dbl = {rep, rep} >> r_val;

    assign result.code_valid = !bad;
    assign result.mask_value = bad ? '0 : dbl[MASK_W-1:0];

endmodule

/* hdl/logical_immediate_decode_unit.sv */
// logical immediate decode unit: streaming wrapper around lid_decode
// depends on lid_pkg and lid_decode
//
// usage:
//   s_ channel carries one 13-bit logical immediate code per item in s_tdata
//   (bit 12 n, bits 11..6 rotate, bits 5..0 size and ones count)
//   m_ channel returns one item per input item: the 64-bit mask in m_tdata
//   and the legality flag in m_tuser; the mask is zero for an illegal code
// path: an accepted item goes through the input register, then the decode
//   logic into the result register, which drives m_tvalid
// throughput: one item per cycle while m_tready is high, set by the single
//   decode pass between the input and result registers
// stall: when m_tready is low the result register holds its item and the
//   input register may still fill, so one more item is taken before s_tready
//   drops; items are never lost or repeated
// reset: aresetn low (synchronous) empties both stages; no item is in flight
//   afterward and s_tready is high on the first cycle out of reset
module logical_immediate_decode_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input item
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lid_pkg::S_TDATA_W-1:0] s_tdata,  // [12:0] imm_code, [15:13] zero
    // result item
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lid_pkg::MASK_W-1:0]    m_tdata,  // [63:0] mask_value
    output logic                          m_tuser   // [0] code_valid
);
    import lid_pkg::*;

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CODE_W-1:0] in_code_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    lid_result_t       out_res_reg;

    lid_result_t       dec_res;
    logic              out_load;   // result stage takes a new value this cycle
    logic              s_accept;

    lid_decode u_decode (
        .imm_code (in_code_reg),
        .result   (dec_res)
    );

    // result stage can take data when empty or when its item is being taken
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_code_reg <= s_tdata[CODE_W-1:0];
        end
        if (out_load && in_valid_reg) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.mask_value;
    assign m_tuser  = out_res_reg.code_valid;

endmodule
